### rtl/ptw_pkg.sv
// Shared types, constants and helpers for the four-level page table engine.
// Used by the walker, the top level and the port checker; depends on nothing.
package ptw_pkg;

    localparam int TABLE_PAGES       = 16;
    localparam int ENTRIES_PER_TABLE = 512;
    localparam int IDX_W             = $clog2(ENTRIES_PER_TABLE);
    localparam int PAGE_W            = $clog2(TABLE_PAGES);
    localparam int ADDR_W            = PAGE_W + IDX_W;
    localparam int STORE_DEPTH       = TABLE_PAGES * ENTRIES_PER_TABLE;
    localparam int FREE_W            = $clog2(TABLE_PAGES + 1);
    localparam int ENTRY_W           = 64;
    localparam int VA_W              = 48;
    localparam int PA_W              = 52;
    localparam int PW_W              = 6;

    localparam logic [PW_W-1:0] PHYS_WIDTH_RESET = PW_W'(52);
    localparam logic [11:0]     TABLE_LINK_FLAGS = 12'h007;

    typedef enum logic [1:0] {
        CMD_MAP   = 2'd0,
        CMD_UNMAP = 2'd1,
        CMD_XLATE = 2'd2
    } cmd_t;

    localparam logic [1:0] STAT_OK         = 2'd0;
    localparam logic [1:0] STAT_NOT_MAPPED = 2'd1;
    localparam logic [1:0] STAT_NO_PAGES   = 2'd2;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOKUP,
        S_EVAL,
        S_FINISH
    } walk_state_t;

    typedef struct packed {
        logic                rd_en;
        logic [ADDR_W-1:0]   rd_addr;
        logic                wr_en;
        logic [ADDR_W-1:0]   wr_addr;
        logic [ENTRY_W-1:0]  wr_data;
    } mem_req_t;

    typedef struct packed {
        logic             valid;
        logic [1:0]       status;
        logic [PA_W-1:0]  phys;
    } walk_res_t;

    // Table index of one walk level, root level first.
    function automatic logic [IDX_W-1:0] level_index(input logic [VA_W-1:0] va,
                                                      input logic [1:0] level);
        logic [IDX_W-1:0] idx;
        unique case (level)
            2'd0: idx = va[47:39];
            2'd1: idx = va[38:30];
            2'd2: idx = va[29:21];
            2'd3: idx = va[20:12];
        endcase
        return idx;
    endfunction

endpackage

### rtl/ptw_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// Standalone; no package dependency.
module ptw_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8192
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/ptw_walker.sv
// Walk sequencer: clears the table store after reset, then runs each command
// as up to four read-evaluate steps on the store. Depends on ptw_pkg.
module ptw_walker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_cmd,
    input  logic [ptw_pkg::VA_W-1:0]      s_va,
    input  logic [ptw_pkg::PA_W-1:0]      s_pa,
    input  logic [ptw_pkg::ENTRY_W-1:0]   s_flags,
    input  logic [ptw_pkg::PW_W-1:0]      phys_width,
    output ptw_pkg::walk_res_t            res,
    input  logic                          res_ready,
    output ptw_pkg::mem_req_t             mem_req,
    input  logic [ptw_pkg::ENTRY_W-1:0]   rd_data
);
    import ptw_pkg::*;

    walk_state_t          state_reg, state_next;
    logic [1:0]           level_reg, level_next;
    logic [PAGE_W-1:0]    page_reg, page_next;
    logic [FREE_W-1:0]    next_free_reg, next_free_next;
    logic [ADDR_W-1:0]    clr_cnt_reg, clr_cnt_next;
    logic [1:0]           cmd_reg, cmd_next;
    logic [VA_W-1:0]      va_reg, va_next;
    logic [PA_W-1:0]      pa_reg, pa_next;
    logic [ENTRY_W-1:0]   flags_reg, flags_next;
    logic [1:0]           status_reg, status_next;
    logic [PA_W-1:0]      phys_reg, phys_next;

    logic [ADDR_W-1:0]    walk_addr;
    logic [PAGE_W-1:0]    fresh_page;
    logic                 ptr_ok;
    logic                 pages_out;
    logic [PA_W-1:0]      width_mask;

    assign walk_addr  = {page_reg, level_index(va_reg, level_reg)};
    assign fresh_page = next_free_reg[PAGE_W-1:0];
    assign ptr_ok     = (rd_data[51:12] < 40'(TABLE_PAGES));
    assign pages_out  = (next_free_reg == FREE_W'(TABLE_PAGES));
    assign width_mask = ~({PA_W{1'b1}} << phys_width) & ~PA_W'(12'hFFF);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            level_reg     <= '0;
            page_reg      <= '0;
            next_free_reg <= FREE_W'(1);
            clr_cnt_reg   <= '0;
        end else begin
            state_reg     <= state_next;
            level_reg     <= level_next;
            page_reg      <= page_next;
            next_free_reg <= next_free_next;
            clr_cnt_reg   <= clr_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg    <= cmd_next;
        va_reg     <= va_next;
        pa_reg     <= pa_next;
        flags_reg  <= flags_next;
        status_reg <= status_next;
        phys_reg   <= phys_next;
    end

    always_comb begin
        state_next     = state_reg;
        level_next     = level_reg;
        page_next      = page_reg;
        next_free_next = next_free_reg;
        clr_cnt_next   = clr_cnt_reg;
        cmd_next       = cmd_reg;
        va_next        = va_reg;
        pa_next        = pa_reg;
        flags_next     = flags_reg;
        status_next    = status_reg;
        phys_next      = phys_reg;
        s_ready        = 1'b0;
        mem_req        = '0;

        unique case (state_reg)
            S_CLEAR: begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = clr_cnt_reg;
                mem_req.wr_data = '0;
                clr_cnt_next    = clr_cnt_reg + ADDR_W'(1);
                if (clr_cnt_reg == {ADDR_W{1'b1}}) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd_next   = s_cmd;
                    va_next    = s_va;
                    pa_next    = s_pa;
                    flags_next = s_flags;
                    level_next = '0;
                    page_next  = '0;
                    phys_next  = '0;
                    if (s_cmd == CMD_MAP || s_cmd == CMD_UNMAP || s_cmd == CMD_XLATE) begin
                        state_next = S_LOOKUP;
                    end else begin
                        status_next = STAT_NOT_MAPPED;
                        state_next  = S_FINISH;
                    end
                end
            end
            S_LOOKUP: begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = walk_addr;
                state_next      = S_EVAL;
            end
            S_EVAL: begin
                if (level_reg != 2'd3) begin
                    if (rd_data[0]) begin
                        if (ptr_ok) begin
                            page_next  = rd_data[12 +: PAGE_W];
                            level_next = level_reg + 2'd1;
                            state_next = S_LOOKUP;
                        end else begin
                            status_next = STAT_NOT_MAPPED;
                            state_next  = S_FINISH;
                        end
                    end else if (cmd_reg != CMD_MAP) begin
                        status_next = STAT_NOT_MAPPED;
                        state_next  = S_FINISH;
                    end else if (pages_out) begin
                        status_next = STAT_NO_PAGES;
                        state_next  = S_FINISH;
                    end else begin
                        // Link a new table; its page is still zero from the clearing pass.
                        mem_req.wr_en   = 1'b1;
                        mem_req.wr_addr = walk_addr;
                        mem_req.wr_data = {12'b0, 40'(fresh_page), TABLE_LINK_FLAGS};
                        page_next       = fresh_page;
                        next_free_next  = next_free_reg + FREE_W'(1);
                        level_next      = level_reg + 2'd1;
                        state_next      = S_LOOKUP;
                    end
                end else begin
                    status_next = STAT_OK;
                    state_next  = S_FINISH;
                    unique case (cmd_reg)
                        CMD_MAP: begin
                            mem_req.wr_en   = 1'b1;
                            mem_req.wr_addr = walk_addr;
                            mem_req.wr_data = {12'b0, pa_reg} | flags_reg;
                        end
                        CMD_UNMAP: begin
                            mem_req.wr_en   = 1'b1;
                            mem_req.wr_addr = walk_addr;
                            mem_req.wr_data = '0;
                        end
                        CMD_XLATE: begin
                            phys_next = (rd_data[PA_W-1:0] & width_mask)
                                        | {40'b0, va_reg[11:0]};
                        end
                        default: begin
                            status_next = STAT_NOT_MAPPED;
                        end
                    endcase
                end
            end
            S_FINISH: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
        endcase
    end

    assign res.valid  = (state_reg == S_FINISH);
    assign res.status = status_reg;
    assign res.phys   = phys_reg;

endmodule

### rtl/four_level_page_table_engine.sv
// Top level of the four-level page table engine: stream ports, width register,
// result register, walk sequencer and table store. Depends on ptw_pkg.
//
//   Channel   Direction  Handshake               Contents
//   s_*       in         s_tvalid / s_tready     one command transaction
//   m_*       out        m_tvalid / m_tready     one result per command
//   cfg_*     in         cfg_valid / cfg_ready   physical width register
//
// After reset all 8192 table store entries are cleared; s_tready stays low meanwhile.
// A full walk runs from acceptance to the next acceptance through four table
// levels, each a read step and an evaluate step on the single store port, then
// one step to hand off the result and one to accept. A walk that stops at a missing
// table or runs out of table pages ends early; an unused command code skips the walk.
// A stalled result holds the walker in its final step only.
module four_level_page_table_engine (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [167:0]  s_tdata,   // virt_addr[47:0], phys_addr[99:48], entry_flags[163:100]
    input  logic [1:0]    s_tuser,   // command[1:0]
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [55:0]   m_tdata,   // phys_result[51:0]
    output logic [1:0]    m_tuser,   // status[1:0]
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [5:0]    cfg_data   // phys_width[5:0]
);
    import ptw_pkg::*;

    logic [PW_W-1:0]     phys_width_reg, phys_width_next;
    logic                m_valid_reg, m_valid_next;
    logic [1:0]          m_status_reg, m_status_next;
    logic [PA_W-1:0]     m_phys_reg, m_phys_next;

    walk_res_t           res;
    logic                res_ready;
    mem_req_t            mem_req;
    logic [ENTRY_W-1:0]  rd_data;

    assign cfg_ready = 1'b1;
    assign res_ready = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phys_width_reg <= PHYS_WIDTH_RESET;
            m_valid_reg    <= 1'b0;
        end else begin
            phys_width_reg <= phys_width_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_status_reg <= m_status_next;
        m_phys_reg   <= m_phys_next;
    end

    always_comb begin
        phys_width_next = phys_width_reg;
        m_valid_next    = m_valid_reg;
        m_status_next   = m_status_reg;
        m_phys_next     = m_phys_reg;
        if (cfg_valid) begin
            phys_width_next = cfg_data;
        end
        if (res.valid && res_ready) begin
            m_valid_next  = 1'b1;
            m_status_next = res.status;
            m_phys_next   = res.phys;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    ptw_walker u_walker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_tvalid),
        .s_ready    (s_tready),
        .s_cmd      (s_tuser),
        .s_va       (s_tdata[47:0]),
        .s_pa       (s_tdata[99:48]),
        .s_flags    (s_tdata[163:100]),
        .phys_width (phys_width_reg),
        .res        (res),
        .res_ready  (res_ready),
        .mem_req    (mem_req),
        .rd_data    (rd_data)
    );

    ptw_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (mem_req.wr_en),
        .wr_addr (mem_req.wr_addr),
        .wr_data (mem_req.wr_data),
        .rd_en   (mem_req.rd_en),
        .rd_addr (mem_req.rd_addr),
        .rd_data (rd_data)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {4'b0, m_phys_reg};

endmodule

### rtl/ptw_checker.sv
// Port-level checker for the page table engine, bound to the top level.
// Depends on ptw_pkg and four_level_page_table_engine.
module ptw_checker (
    input logic          aclk,
    input logic          aresetn,
    input logic          s_tvalid,
    input logic          s_tready,
    input logic          m_tvalid,
    input logic          m_tready,
    input logic [55:0]   m_tdata,
    input logic [1:0]    m_tuser
);
    import ptw_pkg::*;

    // A result transaction that is not taken holds its contents.
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // Every failed command reports a zero address.
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != STAT_OK |-> m_tdata == 56'd0)
        else $error("failed command carries an address");

    // Reset starts the clearing pass with both stream sides quiet.
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !s_tready && !m_tvalid)
        else $error("stream active right after reset");

    // Commands are walked one at a time.
    a_one_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("command accepted during a walk");

endmodule

bind four_level_page_table_engine ptw_checker u_ptw_checker (.*);
